[rtl/core/csl_pkg.sv]
// Shared types and constants for the C subset lexer.
`timescale 1ns / 1ps
`default_nettype none
package csl_pkg;
    // Keyword buffer depth; the keyword compare below is built for exactly this many bytes.
    localparam int KEYWORD_CHARS = 6;

    localparam logic [4:0] K_ID     = 5'd0;
    localparam logic [4:0] K_INT    = 5'd1;
    localparam logic [4:0] K_HEX    = 5'd2;
    localparam logic [4:0] K_FLOAT  = 5'd3;
    localparam logic [4:0] K_SYM0   = 5'd4;
    localparam logic [4:0] K_STAR   = 5'd14;
    localparam logic [4:0] K_ASSIGN = 5'd15;
    localparam logic [4:0] K_RELOP  = 5'd16;
    localparam logic [4:0] K_NOT    = 5'd17;
    localparam logic [4:0] K_AND    = 5'd18;
    localparam logic [4:0] K_OR     = 5'd19;
    localparam logic [4:0] K_ANDBIT = 5'd20;
    localparam logic [4:0] K_ORBIT  = 5'd21;
    localparam logic [4:0] K_IF     = 5'd22;
    localparam logic [4:0] K_ELSE   = 5'd23;
    localparam logic [4:0] K_WHILE  = 5'd24;
    localparam logic [4:0] K_STRUCT = 5'd25;
    localparam logic [4:0] K_RETURN = 5'd26;
    localparam logic [4:0] K_TYPE   = 5'd27;
    localparam logic [4:0] K_FOR    = 5'd28;
    localparam logic [4:0] K_ERROR  = 5'd29;

    typedef enum logic [4:0] {
        S_IDLE, S_IDENT, S_ZERO, S_DEC, S_HEXX, S_HEX, S_DOT, S_FRAC, S_EXP,
        S_EXPSIGN, S_EXPDIG, S_SLASH, S_LCOM, S_BCOM, S_BSTAR, S_EQ, S_BANG,
        S_LTGT, S_AMP, S_BAR
    } scan_state_t;

    // Packed keyword buffer (char 0 in low byte).
    typedef logic [8*KEYWORD_CHARS-1:0] kw6_t;

    function automatic logic [4:0] kw_kind(input kw6_t b, input logic [7:0] len);
        logic [4:0] k;
        k = K_ID;
        if (len == 8'd2 && b[15:0] == 16'h6669) k = K_IF;
        if (len == 8'd4 && b[31:0] == 32'h65736c65) k = K_ELSE;
        if (len == 8'd5 && b[39:0] == 40'h656c696877) k = K_WHILE;
        if (len == 8'd6 && b == 48'h746375727473) k = K_STRUCT;
        if (len == 8'd6 && b == 48'h6e7275746572) k = K_RETURN;
        if (len == 8'd3 && b[23:0] == 24'h746e69) k = K_TYPE;
        if (len == 8'd5 && b[39:0] == 40'h74616f6c66) k = K_TYPE;
        if (len == 8'd4 && b[31:0] == 32'h72616863) k = K_TYPE;
        if (len == 8'd3 && b[23:0] == 24'h726f66) k = K_FOR;
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction
    function automatic logic is_hexd(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction
endpackage
`default_nettype wire

[rtl/core/csl_if.sv]
// Valid/ready stream interfaces for source bytes and tokens.
`timescale 1ns / 1ps
`default_nettype none
interface csl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;
    modport source (output valid, char_code, end_of_text, input ready);
    modport sink (input valid, char_code, end_of_text, output ready);
endinterface

interface csl_out_if #(parameter int LINE_BITS = 16, parameter int OFFSET_BITS = 32);
    logic                   valid;
    logic                   ready;
    logic [4:0]             token_kind;
    logic [LINE_BITS-1:0]   line_number;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [7:0]             token_length;
    logic                   error_seen;
    logic                   last_of_run;
    modport source (output valid, token_kind, line_number, start_offset, token_length,
                    error_seen, last_of_run, input ready);
    modport sink (input valid, token_kind, line_number, start_offset, token_length,
                  error_seen, last_of_run, output ready);
endinterface
`default_nettype wire

[rtl/core/csl_scan.sv]
// Front end: scanner FSM, one byte per in_fire cycle, up to two tokens per byte.
`timescale 1ns / 1ps
`default_nettype none
module csl_scan
    import csl_pkg::*;
#(
    parameter int LINE_BITS = 16,
    parameter int OFFSET_BITS = 32,
    parameter int TOK_W = 1
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic [7:0]       char_code,
    input  wire logic             end_of_text,
    output logic [1:0]            tok_cnt,
    output logic [2*TOK_W-1:0]    tok_data
);
    localparam int KW_IDX = $clog2(KEYWORD_CHARS);

    scan_state_t            state_reg, state_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next, start_reg, start_next;
    logic [7:0]             len_reg, len_next;
    logic                   err_reg, err_next;
    logic [7:0]             kw_reg [KEYWORD_CHARS];
    logic                   kw_we;
    logic [KW_IDX-1:0]      kw_addr;
    kw6_t                   kw_pack;

    always_comb
    begin
        for (int i = 0; i < KEYWORD_CHARS; i++)
            kw_pack[8*i +: 8] = kw_reg[i];
    end

    // Token records: kind, line, start, length, error, last.
    logic [4:0]             k0, k1;
    logic [OFFSET_BITS-1:0] s0, s1;
    logic [7:0]             l0, l1;
    logic                   e0, e1;
    logic [1:0]             n;

    task automatic emit(input logic [4:0] k, input logic [OFFSET_BITS-1:0] s,
                        input logic [7:0] l);
        if (k == K_ERROR) err_next = 1'b1;
        if (n == 2'd0)
        begin
            k0 = k; s0 = s; l0 = l; e0 = err_next;
        end
        else
        begin
            k1 = k; s1 = s; l1 = l; e1 = err_next;
        end
        n = n + 2'd1;
    endtask

    always_comb
    begin
        logic       taken, fl;
        logic [4:0] fk;
        logic [7:0] c;
        logic [7:0] glen;
        c = char_code;
        state_next = state_reg; line_next = line_reg; off_next = off_reg;
        start_next = start_reg; len_next = len_reg; err_next = err_reg;
        kw_we = 1'b0; kw_addr = len_reg[KW_IDX-1:0];
        k0 = K_ID; k1 = K_ID; s0 = '0; s1 = '0; l0 = '0; l1 = '0; e0 = 1'b0; e1 = 1'b0;
        n = 2'd0; taken = 1'b0; fl = 1'b0; fk = K_ID;
        glen = (len_reg == 8'd255) ? len_reg : len_reg + 8'd1;
        unique case (state_reg)
            S_IDENT:   begin fl = 1'b1; fk = (len_reg > 8'(KEYWORD_CHARS)) ? K_ID
                                   : kw_kind(kw_pack, len_reg); end
            S_ZERO, S_DEC: begin fl = 1'b1; fk = K_INT; end
            S_HEX:     begin fl = 1'b1; fk = K_HEX; end
            S_FRAC, S_EXPDIG: begin fl = 1'b1; fk = K_FLOAT; end
            S_HEXX, S_DOT, S_EXP, S_EXPSIGN, S_SLASH: begin fl = 1'b1; fk = K_ERROR; end
            S_EQ:      begin fl = 1'b1; fk = K_ASSIGN; end
            S_BANG:    begin fl = 1'b1; fk = K_NOT; end
            S_LTGT:    begin fl = 1'b1; fk = K_RELOP; end
            S_AMP:     begin fl = 1'b1; fk = K_ANDBIT; end
            S_BAR:     begin fl = 1'b1; fk = K_ORBIT; end
            default:   ;
        endcase
        if (end_of_text)
        begin
            if (fl) emit(fk, start_reg, len_reg);
            state_next = S_IDLE; line_next = '0; off_next = '0;
            start_next = '0; len_next = '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDENT: if (is_alpha(c) || is_digit(c) || c == 8'h5f)
                begin
                    taken = 1'b1; len_next = glen;
                    kw_we = len_reg < 8'(KEYWORD_CHARS);
                end
                S_ZERO:
                    if (c == 8'h78 || c == 8'h58)
                    begin taken = 1'b1; state_next = S_HEXX; len_next = glen; end
                    else if (c == 8'h2e)
                    begin taken = 1'b1; state_next = S_DOT; len_next = glen; end
                S_DEC:
                    if (is_digit(c)) begin taken = 1'b1; len_next = glen; end
                    else if (c == 8'h2e)
                    begin taken = 1'b1; state_next = S_DOT; len_next = glen; end
                S_HEXX, S_HEX: if (is_hexd(c))
                begin taken = 1'b1; state_next = S_HEX; len_next = glen; end
                S_DOT: if (is_digit(c))
                begin taken = 1'b1; state_next = S_FRAC; len_next = glen; end
                S_FRAC:
                    if (is_digit(c)) begin taken = 1'b1; len_next = glen; end
                    else if (c == 8'h65)
                    begin taken = 1'b1; state_next = S_EXP; len_next = glen; end
                S_EXP:
                    if (c == 8'h2b || c == 8'h2d)
                    begin taken = 1'b1; state_next = S_EXPSIGN; len_next = glen; end
                    else if (is_digit(c))
                    begin taken = 1'b1; state_next = S_EXPDIG; len_next = glen; end
                S_EXPSIGN, S_EXPDIG: if (is_digit(c))
                begin taken = 1'b1; state_next = S_EXPDIG; len_next = glen; end
                S_SLASH:
                    if (c == 8'h2f) begin taken = 1'b1; state_next = S_LCOM; end
                    else if (c == 8'h2a) begin taken = 1'b1; state_next = S_BCOM; end
                S_LCOM:
                begin
                    taken = 1'b1;
                    if (c == 8'h0a) state_next = S_IDLE;
                end
                S_BCOM:
                begin
                    taken = 1'b1;
                    if (c == 8'h2a) state_next = S_BSTAR;
                end
                S_BSTAR:
                begin
                    taken = 1'b1;
                    if (c == 8'h2f) state_next = S_IDLE;
                    else if (c != 8'h2a) state_next = S_BCOM;
                end
                S_EQ, S_BANG, S_LTGT: if (c == 8'h3d)
                begin
                    taken = 1'b1; emit(K_RELOP, start_reg, 8'd2); state_next = S_IDLE;
                end
                S_AMP: if (c == 8'h26)
                begin
                    taken = 1'b1; emit(K_AND, start_reg, 8'd2); state_next = S_IDLE;
                end
                S_BAR: if (c == 8'h7c)
                begin
                    taken = 1'b1; emit(K_OR, start_reg, 8'd2); state_next = S_IDLE;
                end
                default: ;
            endcase
            if (!taken)
            begin
                if (fl) emit(fk, start_reg, len_reg);
                start_next = off_reg; len_next = 8'd1; state_next = S_IDLE;
                if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a) ;
                else if (is_alpha(c) || c == 8'h5f)
                begin
                    state_next = S_IDENT; kw_we = 1'b1; kw_addr = '0;
                end
                else if (c == 8'h30) state_next = S_ZERO;
                else if (is_digit(c)) state_next = S_DEC;
                else
                begin
                    priority case (c)
                        8'h2e: state_next = S_DOT;
                        8'h2f: state_next = S_SLASH;
                        8'h3d: state_next = S_EQ;
                        8'h21: state_next = S_BANG;
                        8'h3c, 8'h3e: state_next = S_LTGT;
                        8'h26: state_next = S_AMP;
                        8'h7c: state_next = S_BAR;
                        8'h2a: emit(K_STAR, off_reg, 8'd1);
                        8'h3b: emit(K_SYM0, off_reg, 8'd1);
                        8'h2c: emit(K_SYM0 + 5'd1, off_reg, 8'd1);
                        8'h28: emit(K_SYM0 + 5'd2, off_reg, 8'd1);
                        8'h29: emit(K_SYM0 + 5'd3, off_reg, 8'd1);
                        8'h2b: emit(K_SYM0 + 5'd4, off_reg, 8'd1);
                        8'h2d: emit(K_SYM0 + 5'd5, off_reg, 8'd1);
                        8'h5b: emit(K_SYM0 + 5'd6, off_reg, 8'd1);
                        8'h5d: emit(K_SYM0 + 5'd7, off_reg, 8'd1);
                        8'h7b: emit(K_SYM0 + 5'd8, off_reg, 8'd1);
                        8'h7d: emit(K_SYM0 + 5'd9, off_reg, 8'd1);
                        default: emit(K_ERROR, off_reg, 8'd1);
                    endcase
                end
            end
            // Line count is sampled by tokens before the newline advances it.
            if (c == 8'h0a && line_reg != '1) line_next = line_reg + 1'b1;
            off_next = off_reg + 1'b1;
        end
        tok_cnt = in_fire ? n : 2'd0;
        tok_data = {k1, line_reg, s1, l1, e1, (n == 2'd2),
                    k0, line_reg, s0, l0, e0, (n == 2'd1)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; line_reg <= '0; off_reg <= '0;
            start_reg <= '0; len_reg <= '0; err_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next; line_reg <= line_next; off_reg <= off_next;
            start_reg <= start_next; len_reg <= len_next; err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && kw_we) kw_reg[kw_addr] <= char_code;
    end

`ifndef SYNTH
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |-> tok_cnt == 2'd0) else $error("tokens without transfer");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        $past(err_reg) |-> err_reg) else $error("error flag cleared");
    a_eot: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_text |=> state_reg == S_IDLE && off_reg == '0)
        else $error("end of text did not restart");
`endif
endmodule
`default_nettype wire

[rtl/core/csl_queue.sv]
// Back end: token queue taking up to two entries per cycle, draining one per transfer.
`timescale 1ns / 1ps
`default_nettype none
module csl_queue #(
    parameter int W = 8
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [1:0]   push_cnt,
    input  wire logic [2*W-1:0] push_data,
    output logic              room,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);
    localparam int DEPTH = 4;
    logic [W-1:0] mem [DEPTH];
    logic [1:0]   wr_reg, rd_reg;
    logic [2:0]   cnt_reg;
    logic         pop;

    assign pop = out_valid && out_ready;
    assign out_valid = cnt_reg != 3'd0;
    assign out_data = mem[rd_reg];
    // Two free slots guarantee a byte's worth of tokens fits.
    assign room = cnt_reg <= 3'd2;

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0) mem[wr_reg] <= push_data[W-1:0];
        if (push_cnt == 2'd2) mem[wr_reg + 2'd1] <= push_data[2*W-1:W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_reg + push_cnt;
            rd_reg <= rd_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, push_cnt} - {2'b0, pop};
        end
    end

`ifndef SYNTH
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4) else $error("queue overflow");
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> room) else $error("push without room");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("entry lost");
`endif
endmodule
`default_nettype wire

[rtl/core/c_subset_lexer.sv]
// Top level of the C subset lexer.
// A token enters the token queue when the byte that ends it is transferred.
// Throughput: one byte per cycle while the four-entry token queue has room; it
// drains one token per transfer, so two-token bytes fill it and hold back input.
// Reset: rst_n clears scanner state, counters, error flag and queue at once;
// the keyword buffer is written before it is read and needs no reset.
`timescale 1ns / 1ps
`default_nettype none
module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int LINE_BITS = 16,
    parameter int OFFSET_BITS = 32
)(
    input wire logic clk,
    input wire logic rst_n,
    csl_in_if.sink   in_ch,
    csl_out_if.source out_ch
);
    localparam int TOK_W = 5 + LINE_BITS + OFFSET_BITS + 8 + 2;
    logic [1:0]         tok_cnt;
    logic [2*TOK_W-1:0] tok_data;
    logic [TOK_W-1:0]   head;
    logic               room, in_fire;

    assign in_ch.ready = room;
    assign in_fire = in_ch.valid && room;

    csl_scan #(.LINE_BITS(LINE_BITS),
               .OFFSET_BITS(OFFSET_BITS), .TOK_W(TOK_W)) u_scan (
        .clk, .rst_n, .in_fire, .char_code(in_ch.char_code),
        .end_of_text(in_ch.end_of_text), .tok_cnt, .tok_data);

    csl_queue #(.W(TOK_W)) u_queue (
        .clk, .rst_n, .push_cnt(tok_cnt), .push_data(tok_data), .room,
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(head));

    assign {out_ch.token_kind, out_ch.line_number, out_ch.start_offset,
            out_ch.token_length, out_ch.error_seen, out_ch.last_of_run} = head;
endmodule
`default_nettype wire

[verif/tb_c_subset_lexer.sv]
// Self-checking testbench for the C subset lexer: token prediction, random byte streams.
`timescale 1ns / 1ps
module tb_c_subset_lexer;
    import csl_pkg::*;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } src_byte_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [31:0] start;
        logic [7:0]  len;
        logic        err;
        logic        last;
    } token_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    csl_in_if in_ch();
    csl_out_if #(.LINE_BITS(16), .OFFSET_BITS(32)) out_ch();

    c_subset_lexer uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Lexer shadow state.
    scan_state_t lx_state;
    logic [15:0] lx_line;
    logic [31:0] lx_offset;
    logic [31:0] lx_start;
    logic [7:0]  lx_len;
    logic [7:0]  lx_kw [0:5];
    logic        lx_err;

    src_byte_t pending_bytes[$];
    token_t    expected_tokens[$];
    token_t    step_out[$];

    int mismatch_count = 0;
    int token_count = 0;
    int byte_count = 0;
    int send_idle_pct = 26;
    int recv_idle_pct = 79;
    int hold_recv = 0;
    bit pause_send = 1'b0;
    bit stim_done = 1'b0;
    longint cycle_count = 0;

    function automatic bit is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic [4:0] keyword_kind();
        string s;
        if (lx_len > 6)
            return K_ID;
        s = "";
        for (int i = 0; i < lx_len; i++)
            s = {s, string'(lx_kw[i])};
        case (s)
            "if": return K_IF;
            "else": return K_ELSE;
            "while": return K_WHILE;
            "struct": return K_STRUCT;
            "return": return K_RETURN;
            "int", "float", "char": return K_TYPE;
            "for": return K_FOR;
            default: return K_ID;
        endcase
    endfunction

    task automatic emit(logic [4:0] kind, logic [31:0] start, logic [7:0] len);
        token_t t;
        if (step_out.size() >= 2)
            return;
        if (kind == K_ERROR)
            lx_err = 1'b1;
        t.kind = kind;
        t.line = lx_line;
        t.start = start;
        t.len = len;
        t.err = lx_err;
        t.last = 1'b0;
        step_out.insert(step_out.size(), t);
    endtask

    task automatic flush_token();
        case (lx_state)
            S_IDENT: emit(keyword_kind(), lx_start, lx_len);
            S_ZERO, S_DEC: emit(K_INT, lx_start, lx_len);
            S_HEX: emit(K_HEX, lx_start, lx_len);
            S_FRAC, S_EXPDIG: emit(K_FLOAT, lx_start, lx_len);
            S_HEXX, S_DOT, S_EXP, S_EXPSIGN, S_SLASH: emit(K_ERROR, lx_start, lx_len);
            S_EQ: emit(K_ASSIGN, lx_start, lx_len);
            S_BANG: emit(K_NOT, lx_start, lx_len);
            S_LTGT: emit(K_RELOP, lx_start, lx_len);
            S_AMP: emit(K_ANDBIT, lx_start, lx_len);
            S_BAR: emit(K_ORBIT, lx_start, lx_len);
            default: ;
        endcase
        lx_state = S_IDLE;
    endtask

    function automatic void lengthen();
        if (lx_len < 8'd255)
            lx_len++;
    endfunction

    task automatic extend_token(logic [7:0] c, output bit taken);
        taken = 1'b1;
        case (lx_state)
            S_IDENT:
                if (is_word(c))
                begin
                    if (lx_len < 6)
                        lx_kw[lx_len] = c;
                    lengthen();
                end
                else taken = 1'b0;
            S_ZERO:
                if (c == "x" || c == "X") begin lx_state = S_HEXX; lengthen(); end
                else if (c == ".") begin lx_state = S_DOT; lengthen(); end
                else taken = 1'b0;
            S_DEC:
                if (is_digit(c)) lengthen();
                else if (c == ".") begin lx_state = S_DOT; lengthen(); end
                else taken = 1'b0;
            S_HEXX, S_HEX:
                if (is_hexd(c)) begin lx_state = S_HEX; lengthen(); end
                else taken = 1'b0;
            S_DOT:
                if (is_digit(c)) begin lx_state = S_FRAC; lengthen(); end
                else taken = 1'b0;
            S_FRAC:
                if (is_digit(c)) lengthen();
                else if (c == "e") begin lx_state = S_EXP; lengthen(); end
                else taken = 1'b0;
            S_EXP:
                if (c == "+" || c == "-") begin lx_state = S_EXPSIGN; lengthen(); end
                else if (is_digit(c)) begin lx_state = S_EXPDIG; lengthen(); end
                else taken = 1'b0;
            S_EXPSIGN, S_EXPDIG:
                if (is_digit(c)) begin lx_state = S_EXPDIG; lengthen(); end
                else taken = 1'b0;
            S_SLASH:
                if (c == "/") lx_state = S_LCOM;
                else if (c == "*") lx_state = S_BCOM;
                else taken = 1'b0;
            S_LCOM:
                if (c == 8'h0a) lx_state = S_IDLE;
            S_BCOM:
                if (c == "*") lx_state = S_BSTAR;
            S_BSTAR:
                if (c == "/") lx_state = S_IDLE;
                else if (c != "*") lx_state = S_BCOM;
            S_EQ, S_BANG, S_LTGT:
                if (c == "=") begin emit(K_RELOP, lx_start, 8'd2); lx_state = S_IDLE; end
                else taken = 1'b0;
            S_AMP:
                if (c == "&") begin emit(K_AND, lx_start, 8'd2); lx_state = S_IDLE; end
                else taken = 1'b0;
            S_BAR:
                if (c == "|") begin emit(K_OR, lx_start, 8'd2); lx_state = S_IDLE; end
                else taken = 1'b0;
            default: taken = 1'b0;
        endcase
    endtask

    task automatic start_token(logic [7:0] c);
        lx_start = lx_offset;
        lx_len = 8'd1;
        lx_state = S_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a)
            return;
        if (is_alpha(c) || c == "_")
        begin
            lx_kw[0] = c;
            lx_state = S_IDENT;
        end
        else if (c == "0") lx_state = S_ZERO;
        else if (is_digit(c)) lx_state = S_DEC;
        else
            case (c)
                ".": lx_state = S_DOT;
                "/": lx_state = S_SLASH;
                "=": lx_state = S_EQ;
                "!": lx_state = S_BANG;
                "<", ">": lx_state = S_LTGT;
                "&": lx_state = S_AMP;
                "|": lx_state = S_BAR;
                "*": emit(K_STAR, lx_start, 8'd1);
                ";": emit(K_SYM0 + 5'd0, lx_start, 8'd1);
                ",": emit(K_SYM0 + 5'd1, lx_start, 8'd1);
                "(": emit(K_SYM0 + 5'd2, lx_start, 8'd1);
                ")": emit(K_SYM0 + 5'd3, lx_start, 8'd1);
                "+": emit(K_SYM0 + 5'd4, lx_start, 8'd1);
                "-": emit(K_SYM0 + 5'd5, lx_start, 8'd1);
                "[": emit(K_SYM0 + 5'd6, lx_start, 8'd1);
                "]": emit(K_SYM0 + 5'd7, lx_start, 8'd1);
                "{": emit(K_SYM0 + 5'd8, lx_start, 8'd1);
                "}": emit(K_SYM0 + 5'd9, lx_start, 8'd1);
                default: emit(K_ERROR, lx_start, 8'd1);
            endcase
    endtask

    task automatic predict_tokens(src_byte_t b);
        bit taken;
        step_out.delete();
        if (b.end_of_text)
        begin
            flush_token();
            lx_line = '0;
            lx_offset = '0;
            lx_start = '0;
            lx_len = '0;
        end
        else
        begin
            extend_token(b.char_code, taken);
            if (!taken)
            begin
                flush_token();
                start_token(b.char_code);
            end
            if (b.char_code == 8'h0a && lx_line != 16'hffff)
                lx_line++;
            lx_offset++;
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            expected_tokens.insert(expected_tokens.size(), step_out[i]);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch @%0t token %0d: %s got %0h want %0h",
                 $realtime, token_count, what, got, want);
        mismatch_count++;
    endtask

    // Driver: present the head of the queue, advance on transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_tokens(pending_bytes.pop_front());
                byte_count++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_bytes.size() > 0 && !pause_send &&
                    $urandom_range(99, 0) >= send_idle_pct)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.char_code <= pending_bytes[0].char_code;
                    in_ch.end_of_text <= pending_bytes[0].end_of_text;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver hold-off: count down the stall.
    always @(posedge clk)
    begin
        if (hold_recv > 0)
            hold_recv <= hold_recv - 1;
    end

    // Monitor: compare each transfer against the oldest expected token.
    always @(posedge clk)
    begin
        token_t want;
        cycle_count++;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_tokens.size() == 0)
                    report_mismatch("unexpected token kind", out_ch.token_kind, 0);
                else
                begin
                    want = expected_tokens.pop_front();
                    if (out_ch.token_kind !== want.kind)
                        report_mismatch("token_kind", out_ch.token_kind, want.kind);
                    if (out_ch.line_number !== want.line)
                        report_mismatch("line_number", out_ch.line_number, want.line);
                    if (out_ch.start_offset !== want.start)
                        report_mismatch("start_offset", out_ch.start_offset, want.start);
                    if (out_ch.token_length !== want.len)
                        report_mismatch("token_length", out_ch.token_length, want.len);
                    if (out_ch.error_seen !== want.err)
                        report_mismatch("error_seen", out_ch.error_seen, want.err);
                    if (out_ch.last_of_run !== want.last)
                        report_mismatch("last_of_run", out_ch.last_of_run, want.last);
                end
                token_count++;
            end
            if (hold_recv > 0)
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
        if (cycle_count > 400000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_text(string s);
        src_byte_t b;
        for (int i = 0; i < s.len(); i++)
        begin
            b.char_code = s[i];
            b.end_of_text = 1'b0;
            pending_bytes.insert(pending_bytes.size(), b);
        end
    endtask

    task automatic add_raw(logic [7:0] c, logic eot);
        src_byte_t b;
        b.char_code = c;
        b.end_of_text = eot;
        pending_bytes.insert(pending_bytes.size(), b);
    endtask

    task automatic add_fragment();
        int pick;
        string frags [0:39];
        string puncts;
        string blanks;
        frags = '{"if", "else", "while", "struct", "return", "int", "float", "char",
                  "for", "x_1", "iff", "structs", "_a9", "0", "0x", "0x1F", "0Xab",
                  "07", "123", "1.5", "2.5e+10", "3.0e", "4.e", "1.", ".5", "1e5",
                  "==", "!=", "<=", ">=", "=", "!", "<", ">", "&&", "&", "||", "|",
                  "//c\n", "/*a*b**/"};
        puncts = " ;,()+-[]{}*/\n\t\r.";
        blanks = " \n";
        pick = $urandom_range(99, 0);
        if (pick < 70)
            add_text(frags[$urandom_range(39, 0)]);
        else if (pick < 85)
            add_raw(puncts[$urandom_range(16, 0)], 1'b0);
        else if (pick < 98)
            add_raw(8'($urandom_range(255, 0)), 1'b0);
        else
            add_raw(8'($urandom_range(255, 0)), 1'b1);
        if ($urandom_range(1, 0))
            add_raw(blanks[$urandom_range(1, 0)], 1'b0);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || in_ch.valid || expected_tokens.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.char_code = 8'h00;
        in_ch.end_of_text = 1'b0;
        out_ch.ready = 1'b0;
        lx_state = S_IDLE;
        lx_line = '0;
        lx_offset = '0;
        lx_start = '0;
        lx_len = '0;
        lx_err = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: keywords, numbers, operators, comments, stray bytes, flush.
        add_text("if else while struct return int float char for abcdefgh\n");
        add_text("0 07 0x 0x1f 12.5e-3 1.e 1e5 .x / * */ == != <= && & || | ! = ;");
        add_raw(8'h00, 1'b0);
        add_raw(8'hff, 1'b0);
        add_text("/* open");
        add_raw(8'h00, 1'b1);
        add_text("word");
        add_raw(8'hff, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 26 : 0;
            while (pending_bytes.size() < 370)
                add_fragment();
            if (phase == 2)
            begin
                // Long receiver stall while bytes keep coming.
                while (pending_bytes.size() > 300)
                    @(posedge clk);
                hold_recv = 200;
                wait_drained();
                // Sender pause until all tokens delivered.
                pause_send = 1'b1;
                wait_drained();
                pause_send = 1'b0;
                repeat (200) add_fragment();
            end
            wait_drained();
        end
        add_text("1.5");
        add_raw(8'h00, 1'b1);
        wait_drained();
        repeat (20) @(posedge clk);

        $display("sent %0d bytes, checked %0d tokens under three idle mixes and stalls",
                 byte_count, token_count);
        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
